// File: design/qrrs_pkg.sv
// ============================================================================
// QR Reed-Solomon parity encoder package
// Payload types, sequencer states, field constants and GF(256) arithmetic
// shared by the encoder modules and the port checker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qrrs_pkg;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1.
    localparam logic [8:0] FIELD_POLY = 9'h11D;

    // Parity count after reset and the smallest count the block works with.
    localparam logic [5:0] ECC_RESET = 6'd10;
    localparam logic [5:0] ECC_MIN   = 6'd2;

    // One message byte as it enters the block.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One parity byte as it leaves the block.
    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } out_item_t;

    // Generator build sequencer.
    typedef enum logic {
        GEN_BUILD,
        GEN_READY
    } gen_state_t;

    // Multiply by alpha (x) modulo the field polynomial.
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] shifted;
        shifted = {a[6:0], 1'b0};
        gf_xtime = a[7] ? (shifted ^ FIELD_POLY[7:0]) : shifted;
    endfunction

    // General GF(256) multiply: shift-and-add over the eight bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] term;
        acc  = 8'h00;
        term = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ term;
            end
            term = gf_xtime(term);
        end
        gf_mul = acc;
    endfunction

endpackage

`default_nettype wire

// File: design/qr_reed_solomon_parity_encoder.sv
// ============================================================================
// QR Reed-Solomon parity encoder
// Systematic GF(256) parity generation for QR code blocks.
// ============================================================================
// Usage:
//   Message bytes enter on the in channel (in_valid / in_stall), highest-order
//   coefficient first, with last_byte set on the final byte of a block. One
//   byte is taken per cycle while in_stall is low. After the final byte the
//   block sends as many parity bytes as the parity count on the out channel
//   (out_valid / out_stall), highest order first, with last_parity set on the
//   final one. out_valid rises once the final remainder has passed through
//   the queue and been loaded into the serializer; parity bytes then leave one
//   per cycle while out_stall is low. The front end and the output serializer
//   run in parallel through a two-entry remainder queue.
//   The parity count is written on the cfg channel (cfg_valid / cfg_ready).
//   Each write and each reset rebuilds the generator polynomial, one root per
//   cycle, with cfg_ready low and in_stall high meanwhile. After reset the
//   count is 10, or MAX_ECC if that is smaller, so input opens once the
//   rebuild that follows reset ends. When the receiver stalls, the serializer
//   holds its byte; once the queue fills, in_stall rises and message bytes wait.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qr_reed_solomon_parity_encoder #(
    parameter int MAX_ECC = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire qrrs_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output qrrs_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [5:0]          cfg_data
);

    localparam int CW = $clog2(MAX_ECC + 1);
    localparam int QW = MAX_ECC * 8 + CW;

    logic                 push_valid;
    logic                 push_ready;
    logic [MAX_ECC*8-1:0] push_rem;
    logic [CW-1:0]        push_count;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [QW-1:0]        pop_entry;

    // Front end: configuration, generator build and division register.
    qrrs_front #(
        .MAX_ECC (MAX_ECC),
        .CW      (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rem   (push_rem),
        .push_count (push_count)
    );

    // Queue of finished remainders.
    qrrs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_count, push_rem}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    // Back end: parity byte serializer.
    qrrs_back #(
        .MAX_ECC (MAX_ECC),
        .CW      (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rem   (pop_entry[MAX_ECC*8-1:0]),
        .pop_count (pop_entry[QW-1:MAX_ECC*8]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: design/qrrs_front.sv
// ============================================================================
// QR Reed-Solomon encoder front end
// Holds the parity count, builds the generator polynomial one root per cycle,
// accepts message bytes and runs the division shift register. On the final
// byte of a block the finished remainder is pushed to the parity queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qrrs_front #(
    parameter int MAX_ECC = 32,
    parameter int CW      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Message byte channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire qrrs_pkg::in_item_t    in_data,
    // Parity count write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [5:0]            cfg_data,
    // Finished remainder towards the queue
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output logic [MAX_ECC*8-1:0]       push_rem,
    output logic [CW-1:0]              push_count
);

    localparam logic [6:0] MAX_ECC_W = 7'(MAX_ECC);
    localparam int         RESET_N   = (int'(qrrs_pkg::ECC_RESET) > MAX_ECC)
                                       ? MAX_ECC : int'(qrrs_pkg::ECC_RESET);

    qrrs_pkg::gen_state_t state_reg, state_next;

    logic [CW-1:0] n_reg;
    logic [CW-1:0] step_reg;
    logic [7:0]    root_reg;
    logic [7:0]    gen_reg  [0:MAX_ECC];
    logic [7:0]    gen_next [0:MAX_ECC];
    logic [7:0]    rem_reg  [0:MAX_ECC-1];
    logic [7:0]    rem_next [0:MAX_ECC-1];
    logic [7:0]    rem_up   [0:MAX_ECC-1];
    logic [7:0]    prod     [0:MAX_ECC-1];

    logic          building;
    logic          cfg_fire;
    logic          in_fire;
    logic [6:0]    cfg_ext;
    logic [CW-1:0] eff_count;
    logic [7:0]    fb;

    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire  = in_valid && !in_stall;

    // Clamp the written count into the supported range.
    assign cfg_ext = {1'b0, cfg_data};
    always_comb
    begin
        if (cfg_data < qrrs_pkg::ECC_MIN)
        begin
            eff_count = CW'(qrrs_pkg::ECC_MIN);
        end
        else if (cfg_ext > MAX_ECC_W)
        begin
            eff_count = CW'(MAX_ECC);
        end
        else
        begin
            eff_count = CW'(cfg_ext);
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qrrs_pkg::GEN_BUILD:
            begin
                if (step_reg == n_reg - CW'(1))
                begin
                    state_next = qrrs_pkg::GEN_READY;
                end
            end
            qrrs_pkg::GEN_READY:
            begin
                if (cfg_fire)
                begin
                    state_next = qrrs_pkg::GEN_BUILD;
                end
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        building  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            qrrs_pkg::GEN_BUILD: building  = 1'b1;
            qrrs_pkg::GEN_READY: cfg_ready = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qrrs_pkg::GEN_BUILD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One generator step: multiply the polynomial by (x - alpha^step).
    always_comb
    begin
        gen_next[0] = gen_reg[0];
        for (int j = 1; j <= MAX_ECC; j++)
        begin
            gen_next[j] = gen_reg[j] ^ qrrs_pkg::gf_mul(gen_reg[j-1], root_reg);
        end
    end

    // Generator coefficients, current root and parity count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= CW'(RESET_N);
            step_reg <= '0;
            root_reg <= 8'h01;
            gen_reg[0] <= 8'h01;
            for (int j = 1; j <= MAX_ECC; j++)
            begin
                gen_reg[j] <= 8'h00;
            end
        end
        else if (cfg_fire)
        begin
            n_reg    <= eff_count;
            step_reg <= '0;
            root_reg <= 8'h01;
            gen_reg[0] <= 8'h01;
            for (int j = 1; j <= MAX_ECC; j++)
            begin
                gen_reg[j] <= 8'h00;
            end
        end
        else if (building)
        begin
            step_reg <= step_reg + CW'(1);
            root_reg <= qrrs_pkg::gf_xtime(root_reg);
            for (int j = 0; j <= MAX_ECC; j++)
            begin
                gen_reg[j] <= gen_next[j];
            end
        end
    end

    // Division shift register: each lane takes its upper neighbor (the lane at the
    // count: none) plus the feedback times its generator coefficient. Lanes past the count hold.
    assign fb = in_data.data_byte ^ rem_reg[0];

    always_comb
    begin
        for (int j = 0; j < MAX_ECC - 1; j++)
        begin
            rem_up[j] = rem_reg[j+1];
        end
        rem_up[MAX_ECC-1] = 8'h00;
        for (int j = 0; j < MAX_ECC; j++)
        begin
            prod[j] = qrrs_pkg::gf_mul(fb, gen_reg[j+1]);
            if (CW'(j + 1) < n_reg)
            begin
                rem_next[j] = rem_up[j] ^ prod[j];
            end
            else if (CW'(j + 1) == n_reg)
            begin
                rem_next[j] = prod[j];
            end
            else
            begin
                rem_next[j] = rem_reg[j];
            end
        end
    end

    // Remainder state clears once a block is complete.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_ECC; j++)
            begin
                rem_reg[j] <= 8'h00;
            end
        end
        else if (in_fire)
        begin
            for (int j = 0; j < MAX_ECC; j++)
            begin
                rem_reg[j] <= in_data.last_byte ? 8'h00 : rem_next[j];
            end
        end
    end

    // Input transfers wait while the generator is built or the queue is full.
    assign in_stall   = building || !push_ready;
    assign push_valid = in_fire && in_data.last_byte;
    assign push_count = n_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_ECC; j++)
        begin
            push_rem[j*8 +: 8] = rem_next[j];
        end
    end

endmodule

`default_nettype wire

// File: design/qrrs_queue.sv
// ============================================================================
// QR Reed-Solomon encoder parity queue
// Two-entry queue of finished remainders between the front end and the
// output serializer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qrrs_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/qrrs_back.sv
// ============================================================================
// QR Reed-Solomon encoder back end
// Takes one finished remainder from the queue and sends its bytes out one
// transfer at a time, highest order first, flagging the final byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qrrs_back #(
    parameter int MAX_ECC = 32,
    parameter int CW      = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Remainder from the queue
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire logic [MAX_ECC*8-1:0] pop_rem,
    input  wire logic [CW-1:0]        pop_count,
    // Parity byte channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output qrrs_pkg::out_item_t       out_data
);

    logic                 active_reg;
    logic [MAX_ECC*8-1:0] shift_reg;
    logic [CW-1:0]        left_reg;
    logic                 out_fire;
    logic                 on_last;

    assign on_last  = (left_reg == CW'(1));
    assign out_fire = active_reg && !out_stall;

    // A new block loads when idle or as the final byte of the current one leaves.
    assign pop_ready = !active_reg || (out_fire && on_last);

    assign out_valid            = active_reg;
    assign out_data.parity_byte = shift_reg[7:0];
    assign out_data.last_parity = on_last;

    // Activity flag and remaining byte count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= '0;
        end
        else if (pop_valid && pop_ready)
        begin
            active_reg <= 1'b1;
            left_reg   <= pop_count;
        end
        else if (out_fire)
        begin
            left_reg <= left_reg - CW'(1);
            if (on_last)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Byte shifter.
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            shift_reg <= pop_rem;
        end
        else if (out_fire)
        begin
            shift_reg <= shift_reg >> 8;
        end
    end

endmodule

`default_nettype wire

// File: design/qrrs_checker.sv
// ============================================================================
// QR Reed-Solomon encoder port checker
// Watches the top-level ports for handshake and sequencing slips.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qrrs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire qrrs_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire qrrs_pkg::out_item_t out_data,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic [5:0]          cfg_data
);

    // A stalled parity byte stays valid and unchanged.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("parity byte changed while stalled");

    // A stalled message byte stays valid and unchanged.
    a_in_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("message byte changed while stalled");

    // A pending parity count write stays valid and unchanged.
    a_cfg_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_valid && !cfg_ready |=> cfg_valid && $stable(cfg_data))
        else $error("parity count write changed while waiting");

    // A parity count write starts a generator rebuild, which blocks input.
    a_cfg_rebuild: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
        else $error("input open right after a parity count write");

    // While the generator is being built no message byte may be taken.
    a_build_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("input open during generator build");

endmodule

bind qr_reed_solomon_parity_encoder qrrs_checker u_qrrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire
